/* design/srm_pkg.sv */
package srm_pkg;

	localparam int MAX_SIDES = 16;
	localparam int VEC_W = 32;
	localparam int IDX_W = 4;
	localparam int SIU_W = 5;
	localparam int PROD_W = 2 * VEC_W;
	localparam int ACC_W = PROD_W + 2;
	localparam int CNT_W = $clog2(MAX_SIDES + 1);
	localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam int FRAC_W = 30;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [2:0] {
		REG_CONE_X = 3'd0,
		REG_CONE_Y = 3'd1,
		REG_CONE_Z = 3'd2,
		REG_COS_RADIUS = 3'd3,
		REG_SIDES = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] cone_x;
		logic signed [VEC_W-1:0] cone_y;
		logic signed [VEC_W-1:0] cone_z;
		logic signed [VEC_W-1:0] cos_radius;
		logic [SIU_W-1:0] sides_in_use;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic mode;
		logic [IDX_W-1:0] side_index;
		logic signed [VEC_W-1:0] vec_x;
		logic signed [VEC_W-1:0] vec_y;
		logic signed [VEC_W-1:0] vec_z;
		logic cone_flag;
		logic poly_flag;
	} flow_t;

endpackage

/* design/srm_regs.sv */
module srm_regs import srm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] reg_sel;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign reg_sel = paddr[ADDR_W-1:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cone_x <= '0;
			cfg_q.cone_y <= '0;
			cfg_q.cone_z <= VEC_W'(1 << FRAC_W);
			cfg_q.cos_radius <= VEC_W'(1 << FRAC_W);
			cfg_q.sides_in_use <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_CONE_X: cfg_q.cone_x <= pwdata;
				REG_CONE_Y: cfg_q.cone_y <= pwdata;
				REG_CONE_Z: cfg_q.cone_z <= pwdata;
				REG_COS_RADIUS: cfg_q.cos_radius <= pwdata;
				REG_SIDES: cfg_q.sides_in_use <= pwdata[SIU_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_CONE_X: prdata = cfg_q.cone_x;
			REG_CONE_Y: prdata = cfg_q.cone_y;
			REG_CONE_Z: prdata = cfg_q.cone_z;
			REG_COS_RADIUS: prdata = cfg_q.cos_radius;
			REG_SIDES: prdata = DATA_W'(cfg_q.sides_in_use);
			default: prdata = '0;
		endcase
	end

endmodule

/* design/srm_cone.sv */
module srm_cone import srm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  advance,
	input  cfg_t  cfg,
	input  flow_t flow_i,
	output flow_t flow_o
);

	flow_t flow_s1;
	flow_t flow_s2;
	flow_t flow_next;
	logic signed [PROD_W-1:0] px_s1;
	logic signed [PROD_W-1:0] py_s1;
	logic signed [PROD_W-1:0] pz_s1;
	logic signed [PROD_W-1:0] pc_s1;
	logic signed [ACC_W-1:0] sum;

	always_ff @(posedge clk) begin
		if (advance) begin
			px_s1 <= flow_i.vec_x * cfg.cone_x;
			py_s1 <= flow_i.vec_y * cfg.cone_y;
			pz_s1 <= flow_i.vec_z * cfg.cone_z;
			pc_s1 <= -(PROD_W'(cfg.cos_radius) <<< FRAC_W);
		end
	end

	assign sum = ACC_W'(px_s1) + ACC_W'(py_s1) + ACC_W'(pz_s1) + ACC_W'(pc_s1);

	always_comb begin
		flow_next = flow_s1;
		flow_next.cone_flag = !sum[ACC_W-1] && (sum != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_s1 <= '0;
			flow_s2 <= '0;
		end else if (advance) begin
			flow_s1 <= flow_i;
			flow_s2 <= flow_next;
		end
	end

	assign flow_o = flow_s2;

endmodule

/* design/srm_cell.sv */
module srm_cell import srm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             en,
	input  logic [CNT_W-1:0] cell_idx,
	input  flow_t            flow_i,
	output flow_t            flow_o
);

	flow_t flow_s1;
	flow_t flow_s2;
	flow_t flow_next;
	logic signed [VEC_W-1:0] normal_x_q;
	logic signed [VEC_W-1:0] normal_y_q;
	logic signed [VEC_W-1:0] normal_z_q;
	logic signed [PROD_W-1:0] px_s1;
	logic signed [PROD_W-1:0] py_s1;
	logic signed [PROD_W-1:0] pz_s1;
	logic signed [ACC_W-1:0] sum;
	logic load_hit;

	assign load_hit = flow_i.valid && (flow_i.mode == MODE_LOAD)
		&& (CMP_W'(flow_i.side_index) == CMP_W'(cell_idx));

	always_ff @(posedge clk) begin
		if (advance) begin
			px_s1 <= flow_i.vec_x * normal_x_q;
			py_s1 <= flow_i.vec_y * normal_y_q;
			pz_s1 <= flow_i.vec_z * normal_z_q;
			if (load_hit) begin
				normal_x_q <= flow_i.vec_x;
				normal_y_q <= flow_i.vec_y;
				normal_z_q <= flow_i.vec_z;
			end
		end
	end

	assign sum = ACC_W'(px_s1) + ACC_W'(py_s1) + ACC_W'(pz_s1);

	always_comb begin
		flow_next = flow_s1;
		if (en && !sum[ACC_W-1] && (sum != '0)) begin
			flow_next.poly_flag = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_s1 <= '0;
			flow_s2 <= '0;
		end else if (advance) begin
			flow_s1 <= flow_i;
			flow_s2 <= flow_next;
		end
	end

	assign flow_o = flow_s2;

endmodule

/* design/sky_region_membership.sv */
// Tests sky points against a cone and a convex spherical polygon.
// Items arrive on the item channel (item_valid, item_stall); a transfer
// with mode set to load stores one edge normal into slot side_index, and
// a transfer with mode set to query tests the point vec_x/y/z.
// Each query yields one transfer on the result channel (result_valid,
// result_stall) carrying in_cone and in_polygon; loads yield nothing.
// Items flow in order through a cone stage and a chain of one cell per
// edge normal; each cell holds its normal, registers the products of its
// multiply, then sums and tests them and registers the result flags.
// One item is accepted every cycle while item_stall is low; the chain
// moves as one pipeline.
// When the receiver stalls a waiting result, the whole chain holds and
// item_stall rises until the result transfer completes.
// Reset clears all valid state and loads the register reset values;
// the normal slots hold no defined value until loaded.
// Registers sit on the APB port at byte addresses 0, 4, 8, 12 and 16.
module sky_region_membership import srm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              mode,
	input  logic [IDX_W-1:0]  side_index,
	input  logic [VEC_W-1:0]  vec_x,
	input  logic [VEC_W-1:0]  vec_y,
	input  logic [VEC_W-1:0]  vec_z,
	output logic              result_valid,
	input  logic              result_stall,
	output logic              in_cone,
	output logic              in_polygon
);

	cfg_t cfg;
	flow_t flow_in;
	flow_t chain [0:MAX_SIDES];
	logic advance;
	logic [CNT_W-1:0] n_sat;
	logic result_valid_q;
	logic in_cone_q;
	logic in_polygon_q;

	srm_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	assign n_sat = (int'(cfg.sides_in_use) > MAX_SIDES) ? CNT_W'(MAX_SIDES)
		: CNT_W'(cfg.sides_in_use);

	assign advance = !result_valid_q || !result_stall;
	assign item_stall = !advance;

	always_comb begin
		flow_in.valid = item_valid;
		flow_in.mode = mode;
		flow_in.side_index = side_index;
		flow_in.vec_x = vec_x;
		flow_in.vec_y = vec_y;
		flow_in.vec_z = vec_z;
		flow_in.cone_flag = 1'b0;
		flow_in.poly_flag = (n_sat != '0);
	end

	srm_cone u_cone (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.cfg(cfg),
		.flow_i(flow_in),
		.flow_o(chain[0])
	);

	for (genvar g = 0; g < MAX_SIDES; g++) begin : g_cell
		srm_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.advance(advance),
			.en(g < int'(n_sat)),
			.cell_idx(CNT_W'(g)),
			.flow_i(chain[g]),
			.flow_o(chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= chain[MAX_SIDES].valid && (chain[MAX_SIDES].mode == MODE_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			in_cone_q <= chain[MAX_SIDES].cone_flag;
			in_polygon_q <= chain[MAX_SIDES].poly_flag;
		end
	end

	assign result_valid = result_valid_q;
	assign in_cone = in_cone_q;
	assign in_polygon = in_polygon_q;

endmodule
